>>> rtl/psd_pkg.sv
// Shared constants for the point-to-segment distance block.
package psd_pkg;

	// Default coordinate width in bits.
	localparam int COORD_WIDTH_DEF = 16;

	// Fraction bits of the segment parameter.
	localparam int FRAC_BITS = 16;

	// Width of both result fields.
	localparam int OUT_W = 17;

	// Segment parameter value that stands for one.
	localparam logic [OUT_W-1:0] U_ONE = 17'h10000;

	// Largest distance that the result field can carry.
	localparam logic [OUT_W-1:0] DIST_MAX = 17'h1FFFF;

endpackage

>>> rtl/psd_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module psd_div #(
	parameter int NW = 34,
	parameter int QW = psd_pkg::FRAC_BITS,
	parameter int SBW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [NW-1:0]  num,
	input  logic [NW-1:0]  den,
	input  logic [SBW-1:0] side,
	output logic           out_valid,
	output logic [QW-1:0]  quo,
	output logic [SBW-1:0] side_out
);

	logic           v_s   [QW];
	logic [NW-1:0]  rem_s [QW];
	logic [NW-1:0]  den_s [QW];
	logic [QW-1:0]  q_s   [QW];
	logic [SBW-1:0] sd_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic           v_in;
		logic [NW-1:0]  rem_in;
		logic [NW-1:0]  den_in;
		logic [QW-1:0]  q_in;
		logic [SBW-1:0] sd_in;
		logic [NW:0]    r2;
		logic           ge;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
			assign sd_in  = side;
		end else begin : g_next
			assign v_in   = v_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in   = q_s[k-1];
			assign sd_in  = sd_s[k-1];
		end

		// Shift the partial remainder and try one subtraction.
		assign r2 = {rem_in, 1'b0};
		assign ge = (r2 >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? NW'(r2 - {1'b0, den_in}) : NW'(r2);
				q_s[k]   <= {q_in[QW-2:0], ge};
				den_s[k] <= den_in;
				sd_s[k]  <= sd_in;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign quo       = q_s[QW-1];
	assign side_out  = sd_s[QW-1];

endmodule

>>> rtl/psd_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
module psd_isqrt #(
	parameter int DW = 36,
	parameter int SBW = 17
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [DW-1:0]  radicand,
	input  logic [SBW-1:0] side,
	output logic           out_valid,
	output logic [DW-1:0]  root,
	output logic [SBW-1:0] side_out
);

	localparam int K = DW / 2;

	logic           v_s  [K];
	logic [DW-1:0]  n_s  [K];
	logic [DW-1:0]  r_s  [K];
	logic [SBW-1:0] sd_s [K];

	for (genvar k = 0; k < K; k++) begin : g_step
		logic           v_in;
		logic [DW-1:0]  n_in;
		logic [DW-1:0]  r_in;
		logic [SBW-1:0] sd_in;
		logic [DW-1:0]  b;
		logic [DW-1:0]  t;
		logic           ge;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign n_in  = radicand;
			assign r_in  = '0;
			assign sd_in = side;
		end else begin : g_next
			assign v_in  = v_s[k-1];
			assign n_in  = n_s[k-1];
			assign r_in  = r_s[k-1];
			assign sd_in = sd_s[k-1];
		end

		// Trial subtraction for this pair of radicand bits.
		assign b  = DW'(1) << (DW - 2 - 2 * k);
		assign t  = r_in + b;
		assign ge = (n_in >= t);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k]  <= ge ? (n_in - t) : n_in;
				r_s[k]  <= ge ? ((r_in >> 1) + b) : (r_in >> 1);
				sd_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = v_s[K-1];
	assign root      = r_s[K-1];
	assign side_out  = sd_s[K-1];

endmodule

>>> rtl/point_segment_distance.sv
// Top level of the point-to-segment distance pipeline.
//
// One input beat carries a query point and the two endpoints of a segment,
// all signed COORD_WIDTH-bit coordinates. One output beat carries the
// clamped projection parameter (Q1.16, 65536 means one) and the floor of
// the distance from the point to the closest point on the segment.
// Both channels use valid/ready; a beat moves when both are high.
// A new input beat is taken every cycle while the output is not held up.
// The divider and the square root each give one bit per register stage.
// A degenerate segment gives a parameter of zero, so the distance is
// measured to the start point.
// Reset clears every valid bit; the pipeline then holds no beat.
// When the receiver holds ready low with a result waiting, the whole
// pipeline freezes and in_ready drops, so nothing is lost or repeated.
module point_segment_distance #(
	parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] seg_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg_end_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [psd_pkg::OUT_W-1:0]     distance,
	output logic [psd_pkg::OUT_W-1:0]     seg_param
);

	localparam int W   = COORD_WIDTH;
	localparam int W1  = W + 1;
	localparam int PW  = 2 * W + 2;
	localparam int NW  = 2 * W + 2;
	localparam int DTW = 2 * W + 3;
	localparam int FB  = psd_pkg::FRAC_BITS;
	localparam int OW  = psd_pkg::OUT_W;
	localparam int MW  = W + OW + 2;
	localparam int DXW = W + 4;
	localparam int SQW = 2 * DXW;
	localparam int DW  = 2 * W + 4;
	localparam int SBW = 4 * W1 + 1;

	logic en;
	logic dv_out;
	logic [FB-1:0] quo;
	logic [SBW-1:0] div_side;
	logic [DW-1:0] root;

	// The whole pipeline advances unless a result is held up at the output.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: segment direction and point offset from the start.
	logic                 v_s1;
	logic signed [W1-1:0] ldx_s1, ldy_s1, apx_s1, apy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ldx_s1 <= W1'(seg_end_x) - W1'(seg_start_x);
			ldy_s1 <= W1'(seg_end_y) - W1'(seg_start_y);
			apx_s1 <= W1'(point_x) - W1'(seg_start_x);
			apy_s1 <= W1'(point_y) - W1'(seg_start_y);
		end
	end

	// Stage 2: the four products.
	logic                 v_s2;
	logic signed [PW-1:0] pxx_s2, pyy_s2, pdx_s2, pdy_s2;
	logic signed [W1-1:0] ldx_s2, ldy_s2, apx_s2, apy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s2 <= PW'(ldx_s1) * PW'(ldx_s1);
			pyy_s2 <= PW'(ldy_s1) * PW'(ldy_s1);
			pdx_s2 <= PW'(apx_s1) * PW'(ldx_s1);
			pdy_s2 <= PW'(apy_s1) * PW'(ldy_s1);
			ldx_s2 <= ldx_s1;
			ldy_s2 <= ldy_s1;
			apx_s2 <= apx_s1;
			apy_s2 <= apy_s1;
		end
	end

	// Stage 3: squared length and dot product.
	logic                  v_s3;
	logic [NW-1:0]         norm_s3;
	logic signed [DTW-1:0] dot_s3;
	logic signed [W1-1:0]  ldx_s3, ldy_s3, apx_s3, apy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s3 <= NW'(pxx_s2) + NW'(pyy_s2);
			dot_s3  <= DTW'(pdx_s2) + DTW'(pdy_s2);
			ldx_s3  <= ldx_s2;
			ldy_s3  <= ldy_s2;
			apx_s3  <= apx_s2;
			apy_s3  <= apy_s2;
		end
	end

	// Stage 4: clamp cases; clamped beats pass the divider with a zero numerator.
	logic u_zero, u_one;
	logic                 v_s4;
	logic                 one_s4;
	logic [NW-1:0]        num_s4, den_s4;
	logic signed [W1-1:0] ldx_s4, ldy_s4, apx_s4, apy_s4;

	assign u_zero = (norm_s3 == '0) || dot_s3[DTW-1] || (dot_s3 == '0);
	assign u_one  = !u_zero && ($unsigned(dot_s3) >= DTW'(norm_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			one_s4 <= u_one;
			num_s4 <= (u_zero || u_one) ? '0 : dot_s3[NW-1:0];
			den_s4 <= (u_zero || u_one) ? NW'(1) : norm_s3;
			ldx_s4 <= ldx_s3;
			ldy_s4 <= ldy_s3;
			apx_s4 <= apx_s3;
			apy_s4 <= apy_s3;
		end
	end

	psd_div #(
		.NW  (NW),
		.QW  (FB),
		.SBW (SBW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num       (num_s4),
		.den       (den_s4),
		.side      ({one_s4, ldx_s4, ldy_s4, apx_s4, apy_s4}),
		.out_valid (dv_out),
		.quo       (quo),
		.side_out  (div_side)
	);

	// Stage 5: scale the direction by the parameter.
	logic                 d_one;
	logic signed [W1-1:0] d_ldx, d_ldy, d_apx, d_apy;
	logic [OW-1:0]        u_d;
	logic                 v_s5;
	logic [OW-1:0]        u_s5;
	logic signed [MW-1:0] mx_s5, my_s5;
	logic signed [W1-1:0] apx_s5, apy_s5;

	assign {d_one, d_ldx, d_ldy, d_apx, d_apy} = div_side;
	assign u_d = d_one ? psd_pkg::U_ONE : OW'(quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv_out;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s5   <= u_d;
			mx_s5  <= MW'($signed({1'b0, u_d})) * MW'(d_ldx);
			my_s5  <= MW'($signed({1'b0, u_d})) * MW'(d_ldy);
			apx_s5 <= d_apx;
			apy_s5 <= d_apy;
		end
	end

	// Stage 6: round the closest point and take the offset from the point.
	logic signed [MW-1:0] mx_r, my_r;
	logic                 v_s6;
	logic [OW-1:0]        u_s6;
	logic signed [DXW-1:0] dx_s6, dy_s6;

	assign mx_r = (mx_s5 + MW'(32'sd32768)) >>> FB;
	assign my_r = (my_s5 + MW'(32'sd32768)) >>> FB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s6  <= u_s5;
			dx_s6 <= DXW'(mx_r) - DXW'(apx_s5);
			dy_s6 <= DXW'(my_r) - DXW'(apy_s5);
		end
	end

	// Stage 7: squares of the offset.
	logic                  v_s7;
	logic [OW-1:0]         u_s7;
	logic signed [SQW-1:0] sx_s7, sy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s7  <= u_s6;
			sx_s7 <= SQW'(dx_s6) * SQW'(dx_s6);
			sy_s7 <= SQW'(dy_s6) * SQW'(dy_s6);
		end
	end

	// Stage 8: squared distance.
	logic [SQW-1:0] d2_sum;
	logic           v_s8;
	logic [OW-1:0]  u_s8;
	logic [DW-1:0]  d2_s8;

	assign d2_sum = $unsigned(sx_s7) + $unsigned(sy_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s8  <= u_s7;
			d2_s8 <= d2_sum[DW-1:0];
		end
	end

	psd_isqrt #(
		.DW  (DW),
		.SBW (OW)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s8),
		.radicand  (d2_s8),
		.side      (u_s8),
		.out_valid (out_valid),
		.root      (root),
		.side_out  (seg_param)
	);

	// Saturate the root to the result field.
	assign distance = (root > DW'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX : root[OW-1:0];

endmodule

>>> test/point_segment_distance_tb.sv
// Self-checking testbench for the point-to-segment distance pipeline.
`timescale 1ns / 100ps

module point_segment_distance_tb;

	localparam int CW = psd_pkg::COORD_WIDTH_DEF;
	localparam int LATENCY = 8 + psd_pkg::FRAC_BITS + CW + 2;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t px;
		coord_t py;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} query_t;

	typedef struct packed {
		logic [psd_pkg::OUT_W-1:0] dist_val;
		logic [psd_pkg::OUT_W-1:0] param;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	coord_t point_x = '0, point_y = '0, seg_start_x = '0, seg_start_y = '0;
	coord_t seg_end_x = '0, seg_end_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [psd_pkg::OUT_W-1:0] distance, seg_param;

	query_t pending_queries[$];
	answer_t expected_answers[$];
	int errors = 0;
	int beats_out = 0;
	int beats_in = 0;
	int degenerate_seen = 0;
	bit stimulus_done = 1'b0;

	point_segment_distance dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y),
		.seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
		.seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.distance(distance), .seg_param(seg_param)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Truncated integer square root by the digit-by-digit method.
	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Round a Q16 value to the nearest integer, halves toward plus infinity.
	function automatic longint round_q16(longint v);
		return (v + 32768) >>> psd_pkg::FRAC_BITS;
	endfunction

	// Projection parameter and distance to the closest point on the segment.
	function automatic answer_t project_point(query_t q);
		longint ldx, ldy, dot, u, rem, ox, oy, dx, dy;
		longint unsigned norm, d2, root;
		answer_t a;
		ldx = longint'(q.ex) - longint'(q.sx);
		ldy = longint'(q.ey) - longint'(q.sy);
		norm = ldx * ldx + ldy * ldy;
		dot = (longint'(q.px) - q.sx) * ldx + (longint'(q.py) - q.sy) * ldy;
		if (norm == 0 || dot <= 0) begin
			u = 0;
		end else if (longint'(norm) <= dot) begin
			u = psd_pkg::U_ONE;
		end else begin
			rem = dot;
			u = 0;
			for (int i = 0; i < psd_pkg::FRAC_BITS; i++) begin
				rem <<= 1;
				u <<= 1;
				if (rem >= longint'(norm)) begin
					rem -= norm;
					u |= 1;
				end
			end
		end
		ox = round_q16(u * ldx);
		oy = round_q16(u * ldy);
		dx = q.sx + ox - q.px;
		dy = q.sy + oy - q.py;
		d2 = dx * dx + dy * dy;
		root = int_sqrt(d2);
		if (root > psd_pkg::DIST_MAX) root = psd_pkg::DIST_MAX;
		a.dist_val = root[psd_pkg::OUT_W-1:0];
		a.param = u[psd_pkg::OUT_W-1:0];
		return a;
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 64)) - 32;
			2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: return coord_t'($urandom_range(0, 4000)) - 2000;
		endcase
	endfunction

	// Stimulus: directed corners first, then random queries.
	initial begin
		query_t q;
		coord_t mx, mn;
		int mode;
		mx = 16'sh7FFF;
		mn = 16'sh8000;
		pending_queries.push_back('{0, 0, 0, 0, 0, 0});
		pending_queries.push_back('{100, 50, 7, 7, 7, 7});
		pending_queries.push_back('{mx, mx, mn, mn, mn, mn});
		pending_queries.push_back('{mn, mx, mx, mn, mx, mn});
		pending_queries.push_back('{mx, mx, mn, mn, mx, mn});
		pending_queries.push_back('{mn, mn, mx, mx, mn, mx});
		pending_queries.push_back('{mx, mn, mn, mx, mx, mn});
		pending_queries.push_back('{mn, mx, mn, mn, mx, mx});
		pending_queries.push_back('{-50, 10, 0, 0, 100, 0});
		pending_queries.push_back('{150, 10, 0, 0, 100, 0});
		pending_queries.push_back('{100, 10, 0, 0, 100, 0});
		pending_queries.push_back('{0, 10, 0, 0, 100, 0});
		pending_queries.push_back('{33, 17, 0, 0, 100, 0});
		pending_queries.push_back('{1, 0, 0, 0, 3, 0});
		pending_queries.push_back('{2, 5, 0, 0, 3, 0});
		pending_queries.push_back('{5, 5, -3, -7, 20, 11});
		pending_queries.push_back('{-1, -1, -1, -1, -1, -1});
		pending_queries.push_back('{mx, 0, mx, 0, mn, 0});
		pending_queries.push_back('{0, mn, 0, mx, 0, mn});
		pending_queries.push_back('{12, 0, 3, 1, 23, 1});
		for (int i = 0; i < 1200; i++) begin
			mode = $urandom_range(0, 3);
			q.px = rand_coord(mode);
			q.py = rand_coord(mode);
			q.sx = rand_coord(mode);
			q.sy = rand_coord(mode);
			if ($urandom_range(0, 19) == 0) begin
				q.ex = q.sx;
				q.ey = q.sy;
			end else begin
				q.ex = rand_coord(mode);
				q.ey = rand_coord(mode);
			end
			pending_queries.push_back(q);
		end
	end

	// Reset, then wait for every query to be sent and answered.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_queries.size() == 0 && !in_valid);
		wait (expected_answers.size() == 0);
		repeat (2 * LATENCY) @(posedge clk);
		$display("Sent %0d query beats (%0d degenerate segments), checked %0d result beats.",
			beats_in, degenerate_seen, beats_out);
		if (errors == 0 && expected_answers.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	// Driver: offers one query per beat with a random gap before each.
	int send_gap = 0;
	always @(posedge clk) begin
		query_t q;
		bit taken;
		if (arst_n) begin
			taken = in_valid && in_ready;
			if (taken) begin
				q = '{point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y};
				expected_answers.push_back(project_point(q));
				beats_in++;
				if (seg_start_x == seg_end_x && seg_start_y == seg_end_y)
					degenerate_seen++;
				send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			end
			if (!in_valid || taken) begin
				if (send_gap == 0 && pending_queries.size() != 0) begin
					q = pending_queries.pop_front();
					in_valid <= 1'b1;
					point_x <= q.px;
					point_y <= q.py;
					seg_start_x <= q.sx;
					seg_start_y <= q.sy;
					seg_end_x <= q.ex;
					seg_end_y <= q.ey;
				end else begin
					in_valid <= 1'b0;
					if (send_gap > 0) send_gap--;
				end
			end
		end
	end

	// Receiver stall: random per beat, with one long hold-off early on.
	int stall_left = 0;
	bit long_stall_done = 1'b0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (!long_stall_done && beats_out >= 30) begin
					stall_left = 200;
					long_stall_done = 1'b1;
				end else begin
					stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: compare each result beat with the oldest prediction.
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (expected_answers.size() == 0) begin
				$error("result beat with no prediction waiting");
				errors++;
			end else begin
				e = expected_answers.pop_front();
				if (distance !== e.dist_val) begin
					$error("distance: expected %0d, got %0d", e.dist_val, distance);
					errors++;
				end
				if (seg_param !== e.param) begin
					$error("seg_param: expected %0d, got %0d", e.param, seg_param);
					errors++;
				end
			end
		end
	end

endmodule
